// ----- rtl/ara_pkg.sv -----
`default_nettype none

package ara_pkg;

    localparam int SUM_W        = 20;
    localparam int PROD_W       = 2 * SUM_W;
    localparam int ROOT_W       = SUM_W;
    localparam int CORDIC_SHIFT = 24;
    localparam int CORDIC_W     = 48;
    localparam int STEP_W       = 5;
    localparam int ATAN_W       = 23;
    localparam int ACC_W        = 25;
    localparam int ANGLE_W      = 17;
    localparam int OFFSET_W     = 16;
    localparam int SAMPLE_W     = 16;
    localparam int ROUND_BIAS   = 128;
    localparam int ROUND_SHIFT  = 8;
    localparam int ROLL_LIMIT   = 23040;
    localparam int QUEUE_DEPTH  = 2;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] roll_angle;
        logic                      read_error;
    } out_item_t;

    typedef struct packed {
        logic                    err;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic signed [SUM_W-1:0] sz;
    } grp_cmd_t;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        case (idx)
            5'd0:    val = 23'd2949120;
            5'd1:    val = 23'd1740967;
            5'd2:    val = 23'd919879;
            5'd3:    val = 23'd466945;
            5'd4:    val = 23'd234379;
            5'd5:    val = 23'd117304;
            5'd6:    val = 23'd58666;
            5'd7:    val = 23'd29335;
            5'd8:    val = 23'd14668;
            5'd9:    val = 23'd7334;
            5'd10:   val = 23'd3667;
            5'd11:   val = 23'd1833;
            5'd12:   val = 23'd917;
            5'd13:   val = 23'd458;
            5'd14:   val = 23'd229;
            5'd15:   val = 23'd115;
            5'd16:   val = 23'd57;
            5'd17:   val = 23'd29;
            5'd18:   val = 23'd14;
            5'd19:   val = 23'd7;
            5'd20:   val = 23'd4;
            5'd21:   val = 23'd2;
            5'd22:   val = 23'd1;
            default: val = 23'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ara_stream_if.sv -----
`default_nettype none

interface ara_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/accel_roll_angle_estimator.sv -----
// A read-failure beat passes the group queue and the back end's idle and finish states
// to the output register; a group-closing beat also passes the square, add, root, round
// and rotation states. Throughput: one beat per cycle while the 2-entry group queue has
// room; each group holds the back end for 20 root steps and CORDIC_STEPS rotations.
// Reset: async active-low rst_n clears sums, queue, offset and calibration flag.
`default_nettype none

module accel_roll_angle_estimator #(
    parameter int SAMPLES_PER_GROUP = 4,
    parameter int CORDIC_STEPS      = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    ara_stream_if.sink   sample_in,
    ara_stream_if.source roll_out
);
    ara_pkg::grp_cmd_t push_cmd;
    ara_pkg::grp_cmd_t pop_cmd;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    ara_front #(
        .SAMPLES_PER_GROUP (SAMPLES_PER_GROUP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_in),
        .full      (full),
        .push      (push),
        .cmd       (push_cmd)
    );

    ara_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_cmd),
        .pop     (pop),
        .rd_data (pop_cmd),
        .full    (full),
        .empty   (empty)
    );

    ara_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (pop_cmd),
        .empty    (empty),
        .pop      (pop),
        .roll_out (roll_out)
    );

endmodule

`default_nettype wire

// ----- rtl/ara_fifo.sv -----
`default_nettype none

module ara_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire ara_pkg::grp_cmd_t wr_data,
    input  wire logic             pop,
    output ara_pkg::grp_cmd_t     rd_data,
    output logic                  full,
    output logic                  empty
);
    localparam int PTR_W = (ara_pkg::QUEUE_DEPTH > 1) ? $clog2(ara_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(ara_pkg::QUEUE_DEPTH + 1);

    ara_pkg::grp_cmd_t entries_mem [ara_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(ara_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = entries_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(ara_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(ara_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ara_front.sv -----
`default_nettype none

module ara_front #(
    parameter int SAMPLES_PER_GROUP = 4
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    ara_stream_if.sink        sample_in,
    input  wire logic         full,
    output logic              push,
    output ara_pkg::grp_cmd_t cmd
);
    localparam int CNT_W = (SAMPLES_PER_GROUP > 1) ? $clog2(SAMPLES_PER_GROUP) : 1;

    logic signed [ara_pkg::SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [ara_pkg::SUM_W-1:0] sum_y_reg, sum_y_next;
    logic signed [ara_pkg::SUM_W-1:0] sum_z_reg, sum_z_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic signed [ara_pkg::SUM_W-1:0] add_x, add_y, add_z;
    logic                             beat;
    logic                             last;

    assign sample_in.ready = !full;
    assign beat = sample_in.valid && !full;
    assign last = (count_reg == CNT_W'(SAMPLES_PER_GROUP - 1));

    assign add_x = sum_x_reg + ara_pkg::SUM_W'(sample_in.data.accel_x);
    assign add_y = sum_y_reg + ara_pkg::SUM_W'(sample_in.data.accel_y);
    assign add_z = sum_z_reg + ara_pkg::SUM_W'(sample_in.data.accel_z);

    always_comb
    begin
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sum_z_next = sum_z_reg;
        count_next = count_reg;
        push       = 1'b0;
        cmd.err    = sample_in.data.kind;
        cmd.sx     = add_x;
        cmd.sy     = add_y;
        cmd.sz     = add_z;
        if (beat)
        begin
            if (sample_in.data.kind || last)
            begin
                // drop or close the group
                push       = 1'b1;
                sum_x_next = '0;
                sum_y_next = '0;
                sum_z_next = '0;
                count_next = '0;
            end
            else
            begin
                sum_x_next = add_x;
                sum_y_next = add_y;
                sum_z_next = add_z;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            sum_z_reg <= sum_z_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ara_back.sv -----
`default_nettype none

module ara_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ara_pkg::grp_cmd_t cmd,
    input  wire logic              empty,
    output logic                   pop,
    ara_stream_if.source           roll_out
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ADD,
        S_ROOT,
        S_RND,
        S_ROT,
        S_FIN
    } state_t;

    localparam int SUM_W    = ara_pkg::SUM_W;
    localparam int PROD_W   = ara_pkg::PROD_W;
    localparam int ROOT_W   = ara_pkg::ROOT_W;
    localparam int CW       = ara_pkg::CORDIC_W;
    localparam int STEP_W   = ara_pkg::STEP_W;
    localparam int ACC_W    = ara_pkg::ACC_W;
    localparam int ANGLE_W  = ara_pkg::ANGLE_W;
    localparam int OFFSET_W = ara_pkg::OFFSET_W;

    state_t                        state_reg, state_next;
    logic                          calib_reg, calib_next;
    logic signed [OFFSET_W-1:0]    offset_reg, offset_next;
    logic                          out_valid_reg, out_valid_next;
    ara_pkg::out_item_t            out_data_reg, out_data_next;

    logic                          err_reg;
    logic [SUM_W-1:0]              ax_reg, az_reg;
    logic signed [SUM_W-1:0]       sy_reg;
    logic [PROD_W-1:0]             px_reg, pz_reg;
    logic [PROD_W-1:0]             rem_reg;
    logic [PROD_W-1:0]             res_reg;
    logic [PROD_W-1:0]             bit_reg;
    logic                          zero_reg;
    logic signed [CW-1:0]          cx_reg, cy_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic [STEP_W-1:0]             step_reg;

    logic [SUM_W-1:0]              ax_abs, az_abs;
    logic [PROD_W-1:0]             trial;
    logic [ROOT_W-1:0]             root_rnd;
    logic signed [CW-1:0]          shx, shy;
    logic signed [ACC_W-1:0]       atan_val;
    logic signed [ACC_W-1:0]       rnd_full, rnd_clamp;
    logic signed [ANGLE_W-1:0]     roll;
    logic                          fire;

    assign ax_abs   = cmd.sx[SUM_W-1] ? SUM_W'(~cmd.sx + SUM_W'(1)) : SUM_W'(cmd.sx);
    assign az_abs   = cmd.sz[SUM_W-1] ? SUM_W'(~cmd.sz + SUM_W'(1)) : SUM_W'(cmd.sz);
    assign trial    = res_reg + bit_reg;
    assign root_rnd = res_reg[ROOT_W-1:0] + ROOT_W'(rem_reg > res_reg);
    assign shx      = cx_reg >>> step_reg;
    assign shy      = cy_reg >>> step_reg;
    assign atan_val = ACC_W'(ara_pkg::atan_entry(step_reg));
    assign rnd_full = (acc_reg + ACC_W'(ara_pkg::ROUND_BIAS)) >>> ara_pkg::ROUND_SHIFT;
    assign fire     = !out_valid_reg || roll_out.ready;
    assign pop      = (state_reg == S_IDLE) && !empty;

    always_comb
    begin
        if (rnd_full > ACC_W'(ara_pkg::ROLL_LIMIT))
        begin
            rnd_clamp = ACC_W'(ara_pkg::ROLL_LIMIT);
        end
        else if (rnd_full < -ACC_W'(ara_pkg::ROLL_LIMIT))
        begin
            rnd_clamp = -ACC_W'(ara_pkg::ROLL_LIMIT);
        end
        else
        begin
            rnd_clamp = rnd_full;
        end
        roll = zero_reg ? '0 : ANGLE_W'(rnd_clamp);
    end

    always_comb
    begin
        state_next     = state_reg;
        calib_next     = calib_reg;
        offset_next    = offset_reg;
        out_valid_next = out_valid_reg && !roll_out.ready;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    state_next = cmd.err ? S_FIN : S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (bit_reg[0])
                begin
                    state_next = S_RND;
                end
            end
            S_RND:
            begin
                state_next = S_ROT;
            end
            S_ROT:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fire)
                begin
                    state_next = S_IDLE;
                    if (err_reg)
                    begin
                        out_valid_next           = 1'b1;
                        out_data_next.roll_angle = '0;
                        out_data_next.read_error = 1'b1;
                    end
                    else if (!calib_reg)
                    begin
                        calib_next  = 1'b1;
                        offset_next = OFFSET_W'(roll);
                    end
                    else
                    begin
                        out_valid_next           = 1'b1;
                        out_data_next.roll_angle = roll - ANGLE_W'(offset_reg);
                        out_data_next.read_error = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            calib_reg     <= 1'b0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            calib_reg     <= calib_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        case (state_reg)
            S_IDLE:
            begin
                err_reg <= cmd.err;
                ax_reg  <= ax_abs;
                az_reg  <= az_abs;
                sy_reg  <= cmd.sy;
            end
            S_SQ:
            begin
                px_reg <= ax_reg * ax_reg;
                pz_reg <= az_reg * az_reg;
            end
            S_ADD:
            begin
                rem_reg <= px_reg + pz_reg;
                res_reg <= '0;
                bit_reg <= PROD_W'(1) << (PROD_W - 2);
            end
            S_ROOT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            S_RND:
            begin
                zero_reg <= (root_rnd == '0) && (sy_reg == '0);
                cx_reg   <= CW'({root_rnd, {ara_pkg::CORDIC_SHIFT{1'b0}}});
                cy_reg   <= CW'(sy_reg) <<< ara_pkg::CORDIC_SHIFT;
                acc_reg  <= '0;
                step_reg <= '0;
            end
            S_ROT:
            begin
                if (cy_reg > 0)
                begin
                    cx_reg  <= cx_reg + shy;
                    cy_reg  <= cy_reg - shx;
                    acc_reg <= acc_reg + atan_val;
                end
                else
                begin
                    cx_reg  <= cx_reg - shy;
                    cy_reg  <= cy_reg + shx;
                    acc_reg <= acc_reg - atan_val;
                end
                step_reg <= step_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign roll_out.valid = out_valid_reg;
    assign roll_out.data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/ara_checker.sv -----
`default_nettype none

module ara_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               out_valid,
    input wire logic                               out_ready,
    input wire logic signed [ara_pkg::ANGLE_W-1:0] out_roll,
    input wire logic                               out_err
);
    localparam logic signed [ara_pkg::ANGLE_W-1:0] ROLL_SPAN = 17'sd46080;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat withdrawn while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_roll) && $stable(out_err))
        else $error("result payload changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_err |-> out_roll == '0)
        else $error("error result carries a nonzero angle");

    a_roll_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_roll >= -ROLL_SPAN) && (out_roll <= ROLL_SPAN))
        else $error("roll angle outside twice the clamp limit");

endmodule

bind accel_roll_angle_estimator ara_checker u_ara_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (roll_out.valid),
    .out_ready (roll_out.ready),
    .out_roll  (roll_out.data.roll_angle),
    .out_err   (roll_out.data.read_error)
);

`default_nettype wire
